// File: hdl/afc_pkg.sv
package afc_pkg;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned PRESSURE_W = 10;
  localparam int unsigned ACCEL_W    = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned MAG_W      = ACCEL_W + 1;

  localparam logic [LEVEL_W-1:0] FADE_STEP = 8'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;
  localparam logic [LEVEL_W-1:0] PINK_BLUE = 8'd128;

  // floor(now / 200) = floor((now >> 3) / 25), exact by reciprocal for 29-bit operands
  localparam int unsigned BLINK_HALF_MS   = 200;
  localparam int unsigned BLINK_PRE_SHIFT = 3;
  localparam int unsigned BLINK_DIVISOR   = BLINK_HALF_MS >> BLINK_PRE_SHIFT;
  localparam int unsigned BLINK_X_W       = NOW_W - BLINK_PRE_SHIFT;
  localparam int unsigned BLINK_SHIFT     = 34;
  localparam int unsigned BLINK_RECIP_W   = 30;
  localparam logic [BLINK_RECIP_W-1:0] BLINK_RECIP =
    BLINK_RECIP_W'((64'd1 << BLINK_SHIFT) / BLINK_DIVISOR + 64'd1);
  localparam int unsigned BLINK_PROD_W    = BLINK_X_W + BLINK_RECIP_W;

  localparam logic [PRESSURE_W-1:0] PRESSURE_THR_RST = 10'd400;
  localparam logic [CFG_W-1:0]      MOTION_THR_RST   = 16'd10000;
  localparam logic [CFG_W-1:0]      SAMPLE_INT_RST   = 16'd2000;
  localparam logic [CFG_W-1:0]      FADE_INT_RST     = 16'd30;

  typedef enum logic [1:0] {
    CFG_PRESSURE_THR = 2'd0,
    CFG_MOTION_THR   = 2'd1,
    CFG_SAMPLE_INT   = 2'd2,
    CFG_FADE_INT     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_RED_DOWN   = 3'd0,
    PH_GREEN_UP   = 3'd1,
    PH_BLUE_DOWN  = 3'd2,
    PH_RED_UP     = 3'd3,
    PH_GREEN_DOWN = 3'd4,
    PH_BLUE_UP    = 3'd5
  } fade_phase_t;

  typedef struct packed {
    fade_phase_t        phase;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } fade_state_t;

endpackage

// File: hdl/afc_blink.sv
module afc_blink
  import afc_pkg::*;
(
  input  logic [NOW_W-1:0] now_ms,
  output logic             led_dark
);

  logic [BLINK_X_W-1:0]    x;
  logic [BLINK_PROD_W-1:0] prod;

  assign x        = now_ms[NOW_W-1:BLINK_PRE_SHIFT];
  assign prod     = {{BLINK_RECIP_W{1'b0}}, x} * {{BLINK_X_W{1'b0}}, BLINK_RECIP};
  assign led_dark = prod[BLINK_SHIFT];

endmodule

// File: hdl/afc_fade.sv
module afc_fade
  import afc_pkg::*;
(
  input  fade_state_t cur,
  output fade_state_t nxt
);

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_RED_DOWN: begin
        if (cur.red <= FADE_STEP) begin
          nxt.red   = LEVEL_MIN;
          nxt.phase = PH_GREEN_UP;
        end else begin
          nxt.red = cur.red - FADE_STEP;
        end
      end
      PH_GREEN_UP: begin
        if (cur.green >= LEVEL_MAX - FADE_STEP) begin
          nxt.green = LEVEL_MAX;
          nxt.phase = PH_BLUE_DOWN;
        end else begin
          nxt.green = cur.green + FADE_STEP;
        end
      end
      PH_BLUE_DOWN: begin
        if (cur.blue <= FADE_STEP) begin
          nxt.blue  = LEVEL_MIN;
          nxt.phase = PH_RED_UP;
        end else begin
          nxt.blue = cur.blue - FADE_STEP;
        end
      end
      PH_RED_UP: begin
        if (cur.red >= LEVEL_MAX - FADE_STEP) begin
          nxt.red   = LEVEL_MAX;
          nxt.phase = PH_GREEN_DOWN;
        end else begin
          nxt.red = cur.red + FADE_STEP;
        end
      end
      PH_GREEN_DOWN: begin
        if (cur.green <= FADE_STEP) begin
          nxt.green = LEVEL_MIN;
          nxt.phase = PH_BLUE_UP;
        end else begin
          nxt.green = cur.green - FADE_STEP;
        end
      end
      PH_BLUE_UP: begin
        if (cur.blue >= LEVEL_MAX - FADE_STEP) begin
          nxt.blue  = LEVEL_MAX;
          nxt.phase = PH_RED_DOWN;
        end else begin
          nxt.blue = cur.blue + FADE_STEP;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: hdl/alert_and_rgb_fade_controller_top.sv
// Alert and RGB fade controller. Each input transfer is one control pass and yields exactly
// one result transfer: motor drive, the three LED levels last written and the alert latch.
// One pass is accepted every clock cycle unless in_stall is high. A pass is held in the input
// register after its transfer and moves to the result register when that register is empty or
// the output is not stalled; it is valid at the output while it sits there. All state (alert
// latch, fade colors and phase, fade and sample timestamps, LED levels) updates in the cycle a
// pass moves from the input register to the result register, which sets the one-per-cycle rate.
// The 200 ms blink phase comes from a 29x30-bit reciprocal multiplier in that same cycle.
// Configuration registers take effect on the next pass; write them only while the block is idle.
module alert_and_rgb_fade_controller_top
  import afc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [CFG_W-1:0]          cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [NOW_W-1:0]          in_now_ms,
  input  logic [PRESSURE_W-1:0]     in_pressure,
  input  logic                      in_button,
  input  logic signed [ACCEL_W-1:0] in_accel_x,
  input  logic signed [ACCEL_W-1:0] in_accel_y,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_motor_on,
  output logic [LEVEL_W-1:0]        out_led_red,
  output logic [LEVEL_W-1:0]        out_led_green,
  output logic [LEVEL_W-1:0]        out_led_blue,
  output logic                      out_alert_on
);

  logic [PRESSURE_W-1:0] pressure_thr_r;
  logic [CFG_W-1:0]      motion_thr_r;
  logic [CFG_W-1:0]      sample_int_r;
  logic [CFG_W-1:0]      fade_int_r;

  logic                  v1_r;
  logic                  v2_r;
  logic [NOW_W-1:0]      now_r;
  logic [PRESSURE_W-1:0] pressure_r;
  logic                  button_r;
  logic [ACCEL_W-1:0]    accel_x_r;
  logic [ACCEL_W-1:0]    accel_y_r;

  logic                  alert_r;
  logic                  alert_nxt;
  fade_state_t           fade_r;
  fade_state_t           fade_nxt;
  fade_state_t           fade_step;
  logic [NOW_W-1:0]      last_fade_r;
  logic [NOW_W-1:0]      last_fade_nxt;
  logic [NOW_W-1:0]      last_sample_r;
  logic [NOW_W-1:0]      last_sample_nxt;
  logic                  motor_r;
  logic [LEVEL_W-1:0]    led_red_r;
  logic [LEVEL_W-1:0]    led_green_r;
  logic [LEVEL_W-1:0]    led_blue_r;
  logic [LEVEL_W-1:0]    led_red_nxt;
  logic [LEVEL_W-1:0]    led_green_nxt;
  logic [LEVEL_W-1:0]    led_blue_nxt;

  logic                  out_adv;
  logic                  pass_adv;
  logic                  high;
  logic                  led_dark;
  logic                  fade_due;
  logic                  sample_due;
  logic                  alert_mid;
  logic [MAG_W-1:0]      mag_x;
  logic [MAG_W-1:0]      mag_y;
  logic [NOW_W-1:0]      fade_elapsed;
  logic [NOW_W-1:0]      sample_elapsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressure_thr_r <= PRESSURE_THR_RST;
      motion_thr_r   <= MOTION_THR_RST;
      sample_int_r   <= SAMPLE_INT_RST;
      fade_int_r     <= FADE_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_PRESSURE_THR: pressure_thr_r <= cfg_wdata[PRESSURE_W-1:0];
        CFG_MOTION_THR:   motion_thr_r   <= cfg_wdata;
        CFG_SAMPLE_INT:   sample_int_r   <= cfg_wdata;
        CFG_FADE_INT:     fade_int_r     <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  assign out_adv  = !v2_r || !out_stall;
  assign pass_adv = v1_r && out_adv;
  assign in_stall = v1_r && !out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        v1_r <= in_valid;
      end
      if (out_adv) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_r      <= in_now_ms;
      pressure_r <= in_pressure;
      button_r   <= in_button;
      accel_x_r  <= in_accel_x;
      accel_y_r  <= in_accel_y;
    end
  end

  afc_blink u_blink (
    .now_ms   (now_r),
    .led_dark (led_dark)
  );

  afc_fade u_fade (
    .cur (fade_r),
    .nxt (fade_step)
  );

  assign high           = pressure_r > pressure_thr_r;
  assign fade_elapsed   = now_r - last_fade_r;
  assign sample_elapsed = now_r - last_sample_r;
  assign fade_due       = fade_elapsed >= {{(NOW_W-CFG_W){1'b0}}, fade_int_r};
  assign sample_due     = sample_elapsed >= {{(NOW_W-CFG_W){1'b0}}, sample_int_r};
  assign mag_x = accel_x_r[ACCEL_W-1] ? (MAG_W'(1) << ACCEL_W) - {1'b0, accel_x_r}
                                      : {1'b0, accel_x_r};
  assign mag_y = accel_y_r[ACCEL_W-1] ? (MAG_W'(1) << ACCEL_W) - {1'b0, accel_y_r}
                                      : {1'b0, accel_y_r};

  always_comb begin
    alert_mid     = alert_r;
    fade_nxt      = fade_r;
    last_fade_nxt = last_fade_r;
    led_red_nxt   = led_red_r;
    led_green_nxt = led_green_r;
    led_blue_nxt  = led_blue_r;
    if (alert_r) begin
      if (button_r) begin
        alert_mid     = 1'b0;
        led_red_nxt   = LEVEL_MIN;
        led_green_nxt = LEVEL_MAX;
        led_blue_nxt  = LEVEL_MIN;
      end else begin
        led_red_nxt   = led_dark ? LEVEL_MIN : LEVEL_MAX;
        led_green_nxt = LEVEL_MIN;
        led_blue_nxt  = LEVEL_MIN;
      end
    end else if (high) begin
      led_red_nxt   = LEVEL_MAX;
      led_green_nxt = LEVEL_MIN;
      led_blue_nxt  = PINK_BLUE;
    end else if (fade_due) begin
      last_fade_nxt = now_r;
      fade_nxt      = fade_step;
      led_red_nxt   = fade_step.red;
      led_green_nxt = fade_step.green;
      led_blue_nxt  = fade_step.blue;
    end
  end

  always_comb begin
    alert_nxt       = alert_mid;
    last_sample_nxt = last_sample_r;
    if (sample_due) begin
      last_sample_nxt = now_r;
      if (!alert_mid && (mag_x > {1'b0, motion_thr_r} || mag_y > {1'b0, motion_thr_r})) begin
        alert_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alert_r       <= 1'b0;
      fade_r        <= '{phase: PH_RED_DOWN, red: LEVEL_MAX, green: LEVEL_MIN, blue: LEVEL_MAX};
      last_fade_r   <= '0;
      last_sample_r <= '0;
      motor_r       <= 1'b0;
      led_red_r     <= '0;
      led_green_r   <= '0;
      led_blue_r    <= '0;
    end else if (pass_adv) begin
      alert_r       <= alert_nxt;
      fade_r        <= fade_nxt;
      last_fade_r   <= last_fade_nxt;
      last_sample_r <= last_sample_nxt;
      motor_r       <= high;
      led_red_r     <= led_red_nxt;
      led_green_r   <= led_green_nxt;
      led_blue_r    <= led_blue_nxt;
    end
  end

  assign out_valid     = v2_r;
  assign out_motor_on  = motor_r;
  assign out_led_red   = led_red_r;
  assign out_led_green = led_green_r;
  assign out_led_blue  = led_blue_r;
  assign out_alert_on  = alert_r;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with an empty input register");

  a_fade_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    fade_r.phase <= PH_BLUE_UP)
    else $error("fade phase outside six-phase cycle");

  a_clear_writes_green: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_adv && alert_r && button_r) |=>
      (out_led_red == LEVEL_MIN && out_led_green == LEVEL_MAX && out_led_blue == LEVEL_MIN))
    else $error("alert clear did not write green");
`endif

endmodule
